// ===== rtl/fba_pkg.sv =====
package fba_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_NOSPC  = 2'd2;
    localparam logic [1:0] ST_BROKEN = 2'd3;

    // chain end mark and reserved-block bitmap word
    localparam logic [15:0] END_MARK  = 16'hFF0F;
    localparam logic [15:0] MAP_WORD0 = 16'h8000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_LOAD,
        S_ALLOC_TAKE,
        S_ALLOC_END,
        S_FREE_RD,
        S_FREE_WR,
        S_READ_WAIT
    } t_state;

endpackage

// ===== rtl/fat_bitmap_block_allocator_unit.sv =====
// channel   | signals                                       | direction | handshake
// ----------+-----------------------------------------------+-----------+-------------------
// command   | i_command, i_block_count, i_start_block       | in        | start & !busy
// result    | o_status, o_first_block, o_entry_value,       | out       | o_valid, one cycle
//           | o_free_blocks                                 |           |
//
// flow: unsupported command, zero size and no space answer straight from idle; read
// passes a wait state; allocate reads, loads and scans bitmap words in turn, marks free
// blocks and links them, then ends the chain; free reads and clears each chain block in
// turn. both memories have one write port and a registered read port.
// reset: a clearing pass walks the table, one entry a cycle, with busy high; the bitmap
// words are cleared in the same pass.
// stalls: busy holds off new commands; the result word is shown once and cannot be held.
module fat_bitmap_block_allocator_unit #(
    parameter int NUM_BLOCKS = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [13:0] i_block_count,
    input  logic [12:0] i_start_block,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [12:0] o_first_block,
    output logic [15:0] o_entry_value,
    output logic [13:0] o_free_blocks
);

    // geometry
    localparam int BW        = $clog2(NUM_BLOCKS);              // block index width
    localparam int MAP_WORDS = (NUM_BLOCKS + 15) / 16;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FCW       = $clog2(NUM_BLOCKS + 1);          // free count width

    // state memories: used-block bitmap (msb of word = lowest block) and next table
    logic [15:0] r_map_mem [MAP_WORDS];
    logic [15:0] r_tab_mem [NUM_BLOCKS];
    logic [15:0] r_map_rdata;
    logic [15:0] r_tab_rdata;

    // memory port controls
    logic           map_we;
    logic [WAW-1:0] map_waddr;
    logic [15:0]    map_wdata;
    logic [WAW-1:0] map_raddr;
    logic           tab_we;
    logic [BW-1:0]  tab_waddr;
    logic [15:0]    tab_wdata;
    logic [BW-1:0]  tab_raddr;

    // control and working registers
    fba_pkg::t_state r_state, n_state;
    logic [BW-1:0]   r_clr, n_clr;            // clearing pass pointer
    logic [WAW-1:0]  r_widx, n_widx;          // bitmap word under scan
    logic [15:0]     r_word, n_word;          // working copy of that word
    logic [13:0]     r_count, n_count;        // blocks requested
    logic [13:0]     r_taken, n_taken;        // blocks linked so far
    logic [BW-1:0]   r_last, n_last;          // tail of chain being built
    logic [BW-1:0]   r_first, n_first;        // head of chain being built
    logic [15:0]     r_cur, n_cur;            // chain walk pointer
    logic [13:0]     r_left, n_left;          // chain blocks still to free
    logic [FCW-1:0]  r_free, n_free;

    // result word
    logic        r_valid, n_valid;
    logic [1:0]  r_status, n_status;
    logic [12:0] r_first_out, n_first_out;
    logic [15:0] r_entry, n_entry;
    logic [13:0] r_free_out, n_free_out;

    // helpers
    logic [15:0]      phantom;                // bits past the last block read as used
    logic [15:0]      loaded;
    logic             found;
    logic [3:0]       pick;                   // position of first free bit from msb
    logic [31:0]      pick_blk;
    logic [31:0]      cur_ext;
    logic [31:0]      free_ext;
    logic [31:0]      start_ext;
    logic [31:0]      first_ext;
    logic [FCW+13:0]  free_wide;
    logic [15:0]      cur_bit;
    logic [FCW-1:0]   free_after;             // free count once the chain is taken
    logic [FCW+13:0]  after_wide;

    assign busy          = (r_state != fba_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_first_block = r_first_out;
    assign o_entry_value = r_entry;
    assign o_free_blocks = r_free_out;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        r_map_rdata <= r_map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        r_tab_rdata <= r_tab_mem[tab_raddr];
    end

    // mark bits of the last word that lie past NUM_BLOCKS
    always_comb begin
        for (int b = 0; b < 16; b++) begin
            phantom[b] = ((32'(r_widx) * 16 + 32'(15 - b)) >= NUM_BLOCKS);
        end
    end

    // first free bit of the working word, scanning from the msb (lowest block)
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int j = 0; j < 16; j++) begin
            if (!found && !r_word[15 - j]) begin
                found = 1'b1;
                pick  = 4'(j);
            end
        end
    end

    assign loaded     = r_map_rdata | phantom;
    assign pick_blk   = 32'(r_widx) * 16 + 32'(pick);
    assign cur_ext    = 32'(r_cur);
    assign free_ext   = 32'(r_free);
    assign start_ext  = 32'(i_start_block);
    assign first_ext  = 32'(r_first);
    assign free_wide  = (FCW + 14)'(r_free);
    assign cur_bit    = 16'h8000 >> r_cur[3:0];
    assign free_after = r_free - FCW'(r_count);
    assign after_wide = (FCW + 14)'(free_after);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fba_pkg::S_CLEAR;
            r_clr   <= '0;
            r_free  <= FCW'(NUM_BLOCKS - 1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx      <= n_widx;
        r_word      <= n_word;
        r_count     <= n_count;
        r_taken     <= n_taken;
        r_last      <= n_last;
        r_first     <= n_first;
        r_cur       <= n_cur;
        r_left      <= n_left;
        r_status    <= n_status;
        r_first_out <= n_first_out;
        r_entry     <= n_entry;
        r_free_out  <= n_free_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_widx      = r_widx;
        n_word      = r_word;
        n_count     = r_count;
        n_taken     = r_taken;
        n_last      = r_last;
        n_first     = r_first;
        n_cur       = r_cur;
        n_left      = r_left;
        n_free      = r_free;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_first_out = r_first_out;
        n_entry     = r_entry;
        n_free_out  = r_free_out;

        map_we    = 1'b0;
        map_waddr = r_widx;
        map_wdata = r_word;
        map_raddr = r_widx;
        tab_we    = 1'b0;
        tab_waddr = r_cur[BW-1:0];
        tab_wdata = '0;
        tab_raddr = r_cur[BW-1:0];

        case (r_state)
            fba_pkg::S_CLEAR: begin
                // one table entry a cycle; bitmap words ride along
                tab_we    = 1'b1;
                tab_waddr = r_clr;
                tab_wdata = (r_clr == '0) ? fba_pkg::END_MARK : 16'h0000;
                if (32'(r_clr) < MAP_WORDS) begin
                    map_we    = 1'b1;
                    map_waddr = WAW'(r_clr);
                    map_wdata = (r_clr == '0) ? fba_pkg::MAP_WORD0 : 16'h0000;
                end
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == NUM_BLOCKS - 1) begin
                    n_state = fba_pkg::S_IDLE;
                end
            end

            fba_pkg::S_IDLE: begin
                if (start) begin
                    n_status    = fba_pkg::ST_OK;
                    n_first_out = '0;
                    n_entry     = '0;
                    n_free_out  = free_wide[13:0];
                    case (i_command)
                        fba_pkg::CMD_ALLOC: begin
                            if (i_block_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = fba_pkg::ST_ZERO;
                            end else if (32'(i_block_count) > free_ext) begin
                                n_valid  = 1'b1;
                                n_status = fba_pkg::ST_NOSPC;
                            end else begin
                                n_count = i_block_count;
                                n_taken = '0;
                                n_widx  = '0;
                                n_state = fba_pkg::S_ALLOC_RD;
                            end
                        end
                        fba_pkg::CMD_FREE: begin
                            n_cur   = 16'(i_start_block);
                            n_left  = i_block_count;
                            n_state = fba_pkg::S_FREE_RD;
                        end
                        fba_pkg::CMD_READ: begin
                            if (start_ext < NUM_BLOCKS) begin
                                tab_raddr = start_ext[BW-1:0];
                                n_state   = fba_pkg::S_READ_WAIT;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            fba_pkg::S_ALLOC_RD: begin
                map_raddr = r_widx;
                n_state   = fba_pkg::S_ALLOC_LOAD;
            end

            fba_pkg::S_ALLOC_LOAD: begin
                n_word  = loaded;
                n_state = fba_pkg::S_ALLOC_TAKE;
            end

            fba_pkg::S_ALLOC_TAKE: begin
                if (r_taken == r_count) begin
                    map_we  = 1'b1;
                    n_state = fba_pkg::S_ALLOC_END;
                end else if (!found) begin
                    // word full: write it back and move on
                    map_we  = 1'b1;
                    n_widx  = r_widx + 1'b1;
                    n_state = fba_pkg::S_ALLOC_RD;
                end else begin
                    n_word[4'd15 - pick] = 1'b1;
                    if (r_taken != '0) begin
                        tab_we    = 1'b1;
                        tab_waddr = r_last;
                        tab_wdata = 16'(pick_blk);
                    end else begin
                        n_first = pick_blk[BW-1:0];
                    end
                    n_last  = pick_blk[BW-1:0];
                    n_taken = r_taken + 1'b1;
                end
            end

            fba_pkg::S_ALLOC_END: begin
                tab_we      = 1'b1;
                tab_waddr   = r_last;
                tab_wdata   = fba_pkg::END_MARK;
                n_free      = free_after;
                n_free_out  = after_wide[13:0];
                n_first_out = first_ext[12:0];
                n_status    = fba_pkg::ST_OK;
                n_valid     = 1'b1;
                n_state     = fba_pkg::S_IDLE;
            end

            fba_pkg::S_FREE_RD: begin
                map_raddr = WAW'(cur_ext >> 4);
                tab_raddr = r_cur[BW-1:0];
                if (r_left == '0) begin
                    n_valid    = 1'b1;
                    n_free_out = free_wide[13:0];
                    n_state    = fba_pkg::S_IDLE;
                end else if (cur_ext >= NUM_BLOCKS) begin
                    n_valid    = 1'b1;
                    n_status   = fba_pkg::ST_BROKEN;
                    n_free_out = free_wide[13:0];
                    n_state    = fba_pkg::S_IDLE;
                end else begin
                    n_state = fba_pkg::S_FREE_WR;
                end
            end

            fba_pkg::S_FREE_WR: begin
                tab_we    = 1'b1;
                tab_waddr = r_cur[BW-1:0];
                tab_wdata = '0;
                if ((r_map_rdata & cur_bit) != '0) begin
                    map_we    = 1'b1;
                    map_waddr = WAW'(cur_ext >> 4);
                    map_wdata = r_map_rdata & ~cur_bit;
                    n_free    = r_free + 1'b1;
                end
                n_cur   = r_tab_rdata;
                n_left  = r_left - 1'b1;
                n_state = fba_pkg::S_FREE_RD;
            end

            fba_pkg::S_READ_WAIT: begin
                n_entry = r_tab_rdata;
                n_valid = 1'b1;
                n_state = fba_pkg::S_IDLE;
            end

            default: begin
                n_state = fba_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // the free count never exceeds the block total
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= NUM_BLOCKS)
        else $error("free count above block total");

    // an accepted command keeps the unit busy or answers at once
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted command dropped");

    // failed results (zero size, no space, broken chain) return no chain head
    a_zero_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fba_pkg::ST_OK) |-> (o_first_block == '0))
        else $error("chain head on failed result");

    // the scan never links more blocks than requested
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::S_ALLOC_TAKE) |-> (r_taken <= r_count))
        else $error("allocation overran request");

    // no result word while the clearing pass is running
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::S_CLEAR) |-> !o_valid)
        else $error("result during clearing pass");
`endif

endmodule

// ===== tb/sv/fat_bitmap_block_allocator_unit_test.sv =====
`timescale 1ns / 1ps

module fat_bitmap_block_allocator_unit_test;

    // block count of the instance, kept equal to the default of the block
    localparam int NBLK = 8192;
    // command code that the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // cycles with no word moving before the run is called hung
    localparam int HANG_LIMIT = 200000;
    localparam int RANDOM_WORDS = 600;

    // one result word as the block shows it
    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] first;
        logic [15:0] entry;
        logic [13:0] blocks_free;
    } t_result;

    // a chain the stimulus believes to be live: head block and length
    typedef struct {
        int unsigned head;
        int unsigned len;
    } t_chain;

    // allocator state tracked on the side, plus the words still owed by the block
    class alloc_scoreboard;
        bit          block_used[NBLK];
        logic [15:0] next_ptr[NBLK];
        int unsigned free_total;
        t_result     owed_results[$];
        int          errors;

        function new();
            foreach (block_used[k]) begin
                block_used[k] = 1'b0;
                next_ptr[k]   = '0;
            end
            block_used[0] = 1'b1;
            next_ptr[0]   = fba_pkg::END_MARK;
            free_total    = NBLK - 1;
            errors        = 0;
        endfunction

        // apply one accepted command word and queue the word it must produce
        function t_result record_command(logic [1:0] cmd, logic [13:0] cnt, logic [12:0] blk);
            t_result     exp;
            int unsigned taken;
            int unsigned last;
            int unsigned cur;
            int unsigned nxt;
            int unsigned i;
            exp = '0;
            case (cmd)
                fba_pkg::CMD_ALLOC: begin
                    if (cnt == 0) begin
                        exp.status = fba_pkg::ST_ZERO;
                    end else if (cnt > free_total) begin
                        exp.status = fba_pkg::ST_NOSPC;
                    end else begin
                        taken = 0;
                        last  = 0;
                        for (i = 0; i < NBLK && taken < cnt; i++) begin
                            if (!block_used[i]) begin
                                block_used[i] = 1'b1;
                                if (taken == 0)
                                    exp.first = 13'(i);
                                else
                                    next_ptr[last] = 16'(i);
                                last = i;
                                taken++;
                            end
                        end
                        next_ptr[last] = fba_pkg::END_MARK;
                        free_total -= taken;
                    end
                end
                fba_pkg::CMD_FREE: begin
                    cur = blk;
                    for (i = 0; i < cnt; i++) begin
                        if (cur >= NBLK) begin
                            exp.status = fba_pkg::ST_BROKEN;
                            break;
                        end
                        nxt = next_ptr[cur];
                        // only blocks really in use give space back
                        if (block_used[cur]) begin
                            block_used[cur] = 1'b0;
                            free_total++;
                        end
                        next_ptr[cur] = '0;
                        cur = nxt;
                    end
                end
                fba_pkg::CMD_READ: begin
                    exp.entry = next_ptr[blk];
                end
                default: ;
            endcase
            exp.blocks_free = 14'(free_total);
            owed_results.push_back(exp);
            return exp;
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: status %0d first %0d entry %h free %0d",
                             got.status, got.first, got.entry, got.blocks_free);
                return;
            end
            exp = owed_results.pop_front();
            if (got.status !== exp.status || got.first !== exp.first ||
                got.entry !== exp.entry || got.blocks_free !== exp.blocks_free) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d first %0d/%0d entry %h/%h free %0d/%0d",
                             exp.status, got.status, exp.first, got.first,
                             exp.entry, got.entry, exp.blocks_free, got.blocks_free);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = fba_pkg::CMD_READ;
    logic [13:0] i_block_count = '0;
    logic [12:0] i_start_block = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [12:0] o_first_block;
    logic [15:0] o_entry_value;
    logic [13:0] o_free_blocks;

    alloc_scoreboard sb = new();
    t_chain          live_chains[$];
    int              hang_count = 0;
    // idle pattern: stretches of back-to-back words alternate with random gaps
    int              stretch_left = 0;
    bit              stretch_quiet = 1'b0;

    always #2 i_clk = ~i_clk;

    fat_bitmap_block_allocator_unit #(
        .NUM_BLOCKS(NBLK)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_block_count (i_block_count),
        .i_start_block (i_start_block),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_first_block (o_first_block),
        .o_entry_value (o_entry_value),
        .o_free_blocks (o_free_blocks)
    );

    // result words last one cycle and cannot be held, so take every strobe
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid === 1'b1) begin
            got.status      = o_status;
            got.first       = o_first_block;
            got.entry       = o_entry_value;
            got.blocks_free = o_free_blocks;
            sb.check_result(got);
        end
    end

    // hang detection: count cycles in which no word moves on either side
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            hang_count = 0;
        end else begin
            hang_count++;
            if (hang_count >= HANG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        if (stretch_left == 0) begin
            stretch_left  = $urandom_range(10, 40);
            stretch_quiet = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        return stretch_quiet ? 0 : $urandom_range(0, 14);
    endfunction

    // hand one command word to the block; start stays high into the next word
    // when there is no gap, so it is never lowered and raised in one step
    task automatic send_word(input logic [1:0] cmd, input int unsigned cnt,
                             input int unsigned blk, output t_result exp);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command     <= cmd;
        i_block_count <= 14'(cnt);
        i_start_block <= 13'(blk);
        start         <= 1'b1;
        // accepted at the edge where start is high and busy was low
        do @(posedge i_clk); while (busy !== 1'b0);
        exp = sb.record_command(cmd, 14'(cnt), 13'(blk));
    endtask

    // allocate and remember the chain when it was granted
    task automatic alloc_chain(input int unsigned cnt);
        t_result exp;
        t_chain  c;
        send_word(fba_pkg::CMD_ALLOC, cnt, $urandom_range(0, NBLK - 1), exp);
        if (exp.status == fba_pkg::ST_OK) begin
            c.head = exp.first;
            c.len  = cnt;
            live_chains.push_back(c);
        end
    endtask

    task automatic free_live_chain();
        t_result     exp;
        t_chain      c;
        int          idx;
        int          r;
        int unsigned cnt;
        idx = $urandom_range(0, live_chains.size() - 1);
        c   = live_chains[idx];
        live_chains.delete(idx);
        r   = $urandom_range(0, 99);
        if (r < 70)
            cnt = c.len;
        else if (r < 85)
            cnt = c.len + $urandom_range(1, 3);       // runs into the end mark
        else
            cnt = (c.len > 1) ? $urandom_range(1, c.len - 1) : 1;  // partial, tail leaks
        send_word(fba_pkg::CMD_FREE, cnt, c.head, exp);
    endtask

    task automatic noise_word();
        t_result exp;
        int      r;
        r = $urandom_range(0, 5);
        case (r)
            0: send_word(CMD_UNUSED, $urandom_range(0, NBLK), $urandom_range(0, NBLK - 1), exp);
            1: send_word(fba_pkg::CMD_ALLOC, 0, $urandom_range(0, NBLK - 1), exp);
            2: send_word(fba_pkg::CMD_ALLOC, $urandom_range(sb.free_total + 1, NBLK), 0, exp);
            3: send_word(fba_pkg::CMD_FREE, 0, $urandom_range(0, NBLK - 1), exp);
            // free at a random spot: free blocks, block zero loops, stale chains
            default: send_word(fba_pkg::CMD_FREE, $urandom_range(1, 8),
                               $urandom_range(0, NBLK - 1), exp);
        endcase
    endtask

    initial begin
        t_result exp;
        int      sent;
        int      r;
        int      blk;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: the block waits out its clearing pass behind busy
        send_word(fba_pkg::CMD_READ, 0, 0, exp);         // reserved block holds end mark
        send_word(CMD_UNUSED, NBLK, NBLK - 1, exp);      // ignored command, start block all ones
        send_word(fba_pkg::CMD_ALLOC, 0, 0, exp);        // zero size
        send_word(fba_pkg::CMD_ALLOC, NBLK, 0, exp);     // too little space
        send_word(fba_pkg::CMD_ALLOC, 1, NBLK - 1, exp);
        send_word(fba_pkg::CMD_ALLOC, 3, 0, exp);
        send_word(fba_pkg::CMD_READ, 0, 1, exp);
        send_word(fba_pkg::CMD_READ, 0, 2, exp);
        send_word(fba_pkg::CMD_FREE, 1, 2, exp);         // head of a chain only
        send_word(fba_pkg::CMD_FREE, 5, 3, exp);         // too long, hits the end mark
        send_word(fba_pkg::CMD_FREE, 0, 1, exp);         // zero length
        send_word(fba_pkg::CMD_FREE, 2, 2, exp);         // free block, then block zero
        send_word(fba_pkg::CMD_ALLOC, 2, 0, exp);        // block zero handed out
        send_word(fba_pkg::CMD_FREE, 2, 0, exp);
        send_word(fba_pkg::CMD_FREE, 1, 1, exp);         // now every block is free
        send_word(fba_pkg::CMD_ALLOC, NBLK, 0, exp);     // whole space in one chain
        send_word(fba_pkg::CMD_ALLOC, 1, 0, exp);        // full
        send_word(fba_pkg::CMD_READ, 0, NBLK - 1, exp);
        send_word(fba_pkg::CMD_READ, 0, 4095, exp);
        send_word(fba_pkg::CMD_FREE, NBLK, 0, exp);      // release the whole chain
        send_word(fba_pkg::CMD_READ, NBLK, NBLK - 1, exp);
        send_word(fba_pkg::CMD_FREE, 3, NBLK - 1, exp);  // free blocks, loops on block zero
        send_word(fba_pkg::CMD_ALLOC, 1, 0, exp);

        // random part: mostly allocate / read / free of live chains
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            // keep the map from filling up so scans stay short
            if ((sb.free_total < 2000 || live_chains.size() > 48) && r < 60)
                r = 45;
            if (r < 38) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    alloc_chain($urandom_range(1, 16));
                else if (r < 97)
                    alloc_chain($urandom_range(17, 300));
                else
                    alloc_chain($urandom_range(301, 3000));
                sent++;
            end else if (r < 68) begin
                if (live_chains.size() > 0)
                    free_live_chain();
                else
                    alloc_chain($urandom_range(1, 16));
                sent++;
            end else if (r < 88) begin
                if (live_chains.size() > 0 && $urandom_range(0, 1) == 0)
                    blk = live_chains[$urandom_range(0, live_chains.size() - 1)].head;
                else
                    blk = $urandom_range(0, NBLK - 1);
                send_word(fba_pkg::CMD_READ, $urandom_range(0, NBLK), blk, exp);
                sent++;
            end else begin
                noise_word();
                if (i_command != CMD_UNUSED)
                    sent++;
            end
        end
        start <= 1'b0;

        // drain: every command gives exactly one word
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fba_pkg.sv
rtl/fat_bitmap_block_allocator_unit.sv
tb/sv/fat_bitmap_block_allocator_unit_test.sv
